### rtl/ldts_pkg.sv
// ----------------------------------------------------------------------------
// ldts_pkg: shared types, constants and frame functions
// Item kinds, sequencer states, command bytes and the line-level tables of
// the two-wire display frames.
// ----------------------------------------------------------------------------
`default_nettype none

package ldts_pkg;

  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_INIT      = 3'd1;
  localparam logic [2:0] CMD_BRIGHT    = 3'd2;
  localparam logic [2:0] CMD_WRITE     = 3'd3;
  localparam logic [2:0] CMD_COLON_ON  = 3'd4;
  localparam logic [2:0] CMD_COLON_OFF = 3'd5;

  localparam int         DIGIT_COUNT    = 4;
  localparam logic [2:0] COLON_POSITION = 3'd1;
  localparam logic [7:0] DOT_MASK       = 8'd128;

  localparam logic [7:0] MODE_CMD       = 8'h40;
  localparam logic [7:0] FIXED_ADDR_CMD = 8'h40 | 8'h04;
  localparam logic [7:0] CTRL_FULL_CMD  = 8'h80 | 8'h08 | 8'h07;
  localparam logic [7:0] BRIGHT_BASE    = 8'h80 | 8'h08;
  localparam logic [7:0] ADDR_BASE      = 8'hC0;

  localparam int CMD_FRAME_TICKS  = 22;
  localparam int DATA_FRAME_TICKS = 63;
  localparam int PHASE_W          = $clog2(DATA_FRAME_TICKS);

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_INIT,
    KIND_BRIGHT,
    KIND_WRITE,
    KIND_COLON_ON,
    KIND_COLON_OFF,
    KIND_NONE
  } kind_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_INIT_MODE,
    SEQ_INIT_CTRL,
    SEQ_INIT_CLEAR,
    SEQ_ONE_CMD,
    SEQ_ONE_DATA
  } seq_t;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] pos;
    logic [7:0] data_b;
  } item_t;

  typedef struct packed {
    logic accepted;
    logic busy_res;
    logic data_line;
    logic clock_line;
  } res_t;

  // Levels are {clock, data}.
  function automatic logic [1:0] byte_slot(input logic [7:0] b, input logic [4:0] k);
    logic [1:0] lv;
    if (k < 5'd16) begin
      lv = {k[0], b[k[3:1]]};
    end else begin
      lv = {k[0], 1'b0};
    end
    return lv;
  endfunction

  function automatic logic [1:0] cmd_frame(input logic [7:0] b,
                                           input logic [PHASE_W-1:0] t);
    logic [1:0] lv;
    logic [4:0] k;
    k = 5'(t - PHASE_W'(2));
    if (t == PHASE_W'(0)) begin
      lv = 2'b11;
    end else if (t == PHASE_W'(1)) begin
      lv = 2'b10;
    end else if (t < PHASE_W'(20)) begin
      lv = byte_slot(b, k);
    end else if (t == PHASE_W'(20)) begin
      lv = 2'b00;
    end else begin
      lv = 2'b10;
    end
    return lv;
  endfunction

  function automatic logic [1:0] data_frame(input logic [2:0] addr, input logic [7:0] data,
                                            input logic [PHASE_W-1:0] t);
    logic [1:0] lv;
    logic [4:0] ka;
    logic [4:0] kd;
    ka = 5'(t - PHASE_W'(24));
    kd = 5'(t - PHASE_W'(42));
    if (t < PHASE_W'(22)) begin
      lv = cmd_frame(FIXED_ADDR_CMD, t);
    end else if (t == PHASE_W'(22)) begin
      lv = 2'b11;
    end else if (t == PHASE_W'(23)) begin
      lv = 2'b10;
    end else if (t < PHASE_W'(42)) begin
      lv = byte_slot(ADDR_BASE | {5'd0, addr}, ka);
    end else if (t < PHASE_W'(60)) begin
      lv = byte_slot(data, kd);
    end else if (t == PHASE_W'(60)) begin
      lv = 2'b00;
    end else if (t == PHASE_W'(61)) begin
      lv = 2'b10;
    end else begin
      lv = 2'b11;
    end
    return lv;
  endfunction

endpackage

`default_nettype wire

### rtl/ldts_front.sv
// ----------------------------------------------------------------------------
// ldts_front: input decode stage
// Accepts input items, classifies the command and prepares the byte that
// the back end will send, then hands a decoded item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ldts_front
  import ldts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] command,
  input  wire logic [2:0] position,
  input  wire logic [7:0] segments,
  input  wire logic [2:0] level,
  output logic            f_valid,
  input  wire logic       f_ready,
  output item_t           f_item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  item_t item_nxt;

  always_comb begin
    item_nxt.pos    = position;
    item_nxt.data_b = segments;
    case (command)
      CMD_TICK:      item_nxt.kind = KIND_TICK;
      CMD_INIT:      item_nxt.kind = KIND_INIT;
      CMD_BRIGHT: begin
        item_nxt.kind   = KIND_BRIGHT;
        item_nxt.data_b = BRIGHT_BASE | {5'd0, level};
      end
      CMD_WRITE:     item_nxt.kind = KIND_WRITE;
      CMD_COLON_ON:  item_nxt.kind = KIND_COLON_ON;
      CMD_COLON_OFF: item_nxt.kind = KIND_COLON_OFF;
      default:       item_nxt.kind = KIND_NONE;
    endcase
  end

  assign in_ready  = !valid_r || f_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign f_valid = valid_r;
  assign f_item  = item_r;

endmodule

`default_nettype wire

### rtl/ldts_queue.sv
// ----------------------------------------------------------------------------
// ldts_queue: decoded item queue
// A short first-in first-out buffer between the decode stage and the frame
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ldts_queue
  import ldts_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_item,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output item_t      pop_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count_r != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

### rtl/ldts_back.sv
// ----------------------------------------------------------------------------
// ldts_back: frame sequencer
// Runs command sequences tick by tick, drives the clock and data levels and
// keeps the colon and pending write state. Results leave through an output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module ldts_back
  import ldts_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  wire item_t q_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output res_t       out_res
);

  seq_t               step_r;
  seq_t               step_nxt;
  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;
  logic [7:0]         shift_r;
  logic [7:0]         shift_nxt;
  logic [2:0]         addr_r;
  logic [2:0]         addr_nxt;
  logic [7:0]         data_r;
  logic [7:0]         data_nxt;
  logic [2:0]         clear_r;
  logic [2:0]         clear_nxt;
  logic               colon_r;
  logic               colon_nxt;
  logic [7:0]         colon_byte_r;
  logic [7:0]         colon_byte_nxt;
  logic [1:0]         line_r;
  logic [1:0]         line_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  res_t               res_r;
  res_t               res_nxt;
  logic               is_data;
  logic               frame_end;
  logic               acc;
  logic               pop;

  assign pop     = q_valid && (!out_valid_r || out_ready);
  assign q_ready = !out_valid_r || out_ready;
  assign is_data = (step_r == SEQ_INIT_CLEAR) || (step_r == SEQ_ONE_DATA);

  always_comb begin
    step_nxt       = step_r;
    phase_nxt      = phase_r;
    shift_nxt      = shift_r;
    addr_nxt       = addr_r;
    data_nxt       = data_r;
    clear_nxt      = clear_r;
    colon_nxt      = colon_r;
    colon_byte_nxt = colon_byte_r;
    line_nxt       = line_r;
    acc            = 1'b0;
    frame_end      = 1'b0;
    out_valid_nxt  = out_valid_r;
    res_nxt        = res_r;
    if (pop) begin
      case (q_item.kind)
        KIND_TICK: begin
          if (step_r != SEQ_IDLE) begin
            if (is_data) begin
              line_nxt  = data_frame(addr_r, data_r, phase_r);
              frame_end = phase_r == PHASE_W'(DATA_FRAME_TICKS - 1);
            end else begin
              line_nxt  = cmd_frame(shift_r, phase_r);
              frame_end = phase_r == PHASE_W'(CMD_FRAME_TICKS - 1);
            end
            phase_nxt = phase_r + PHASE_W'(1);
            if (frame_end) begin
              phase_nxt = '0;
              case (step_r)
                SEQ_INIT_MODE: begin
                  step_nxt  = SEQ_INIT_CTRL;
                  shift_nxt = CTRL_FULL_CMD;
                end
                SEQ_INIT_CTRL: begin
                  step_nxt  = SEQ_INIT_CLEAR;
                  clear_nxt = '0;
                  addr_nxt  = '0;
                  data_nxt  = '0;
                end
                SEQ_INIT_CLEAR: begin
                  if ({1'b0, clear_r} + 4'd1 >= 4'(DIGIT_COUNT)) begin
                    step_nxt = SEQ_IDLE;
                  end else begin
                    clear_nxt = clear_r + 3'd1;
                    addr_nxt  = clear_r + 3'd1;
                    data_nxt  = '0;
                  end
                end
                default: step_nxt = SEQ_IDLE;
              endcase
            end
          end
        end
        KIND_INIT, KIND_BRIGHT, KIND_WRITE, KIND_COLON_ON, KIND_COLON_OFF: begin
          if (step_r == SEQ_IDLE) begin
            acc       = 1'b1;
            phase_nxt = '0;
            case (q_item.kind)
              KIND_INIT: begin
                step_nxt  = SEQ_INIT_MODE;
                shift_nxt = MODE_CMD;
                clear_nxt = '0;
              end
              KIND_BRIGHT: begin
                step_nxt  = SEQ_ONE_CMD;
                shift_nxt = q_item.data_b;
              end
              KIND_WRITE: begin
                step_nxt = SEQ_ONE_DATA;
                addr_nxt = q_item.pos;
                data_nxt = q_item.data_b | (colon_r ? DOT_MASK : 8'd0);
                if (q_item.pos == COLON_POSITION) begin
                  colon_byte_nxt = q_item.data_b;
                end
              end
              KIND_COLON_ON: begin
                colon_nxt = 1'b1;
                step_nxt  = SEQ_ONE_DATA;
                addr_nxt  = COLON_POSITION;
                data_nxt  = colon_byte_r | DOT_MASK;
              end
              default: begin
                colon_nxt = 1'b0;
                step_nxt  = SEQ_ONE_DATA;
                addr_nxt  = COLON_POSITION;
                data_nxt  = colon_byte_r;
              end
            endcase
          end
        end
        default: ;
      endcase
      out_valid_nxt      = 1'b1;
      res_nxt.clock_line = line_nxt[1];
      res_nxt.data_line  = line_nxt[0];
      res_nxt.busy_res   = step_nxt != SEQ_IDLE;
      res_nxt.accepted   = acc;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= SEQ_IDLE;
      phase_r      <= '0;
      shift_r      <= '0;
      addr_r       <= '0;
      data_r       <= '0;
      clear_r      <= '0;
      colon_r      <= 1'b0;
      colon_byte_r <= '0;
      line_r       <= 2'b11;
      out_valid_r  <= 1'b0;
    end else begin
      step_r       <= step_nxt;
      phase_r      <= phase_nxt;
      shift_r      <= shift_nxt;
      addr_r       <= addr_nxt;
      data_r       <= data_nxt;
      clear_r      <= clear_nxt;
      colon_r      <= colon_nxt;
      colon_byte_r <= colon_byte_nxt;
      line_r       <= line_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.accepted |-> res_r.busy_res)
    else $error("accepted command did not start a sequence");

  a_idle_phase : assert property (@(posedge clk) disable iff (!rst_n)
    step_r == SEQ_IDLE |-> phase_r == '0)
    else $error("phase not zero while idle");

  a_cmd_phase : assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == SEQ_INIT_MODE || step_r == SEQ_INIT_CTRL || step_r == SEQ_ONE_CMD)
      |-> phase_r < PHASE_W'(CMD_FRAME_TICKS))
    else $error("command frame phase out of range");

  a_data_phase : assert property (@(posedge clk) disable iff (!rst_n)
    is_data |-> phase_r < PHASE_W'(DATA_FRAME_TICKS))
    else $error("data frame phase out of range");

endmodule

`default_nettype wire

### rtl/led_driver_two_wire_sender.sv
// ----------------------------------------------------------------------------
// led_driver_two_wire_sender: two-wire LED display driver sender
// Takes tick and command items and returns the clock and data pin levels,
// a busy flag and the acceptance of each command.
// ----------------------------------------------------------------------------
// Every input item gives exactly one result item. The block takes one item
// per clock cycle unless the result side holds it back; a result passes
// through the decode register, the queue and the output register, and the
// sequencer in the back end updates its frame state once per item. Commands are
// refused while a sequence is still being sent, and each tick advances the
// current frame by one half-bit step.
`default_nettype none

module led_driver_two_wire_sender
  import ldts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // position[2:0], segments[10:3], level[13:11]
  input  wire logic [2:0]  in_tuser,  // command[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata  // clock_line[0], data_line[1], busy_res[2], accepted[3]
);

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;
  res_t  res;

  ldts_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .command  (in_tuser),
    .position (in_tdata[2:0]),
    .segments (in_tdata[10:3]),
    .level    (in_tdata[13:11]),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_item   (f_item)
  );

  ldts_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  ldts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {4'd0, res};

endmodule

`default_nettype wire

### dv/led_driver_two_wire_sender_tb.sv
// ----------------------------------------------------------------------------
// led_driver_two_wire_sender_tb: self-checking bench for the two-wire sender
// Drives tick and command requests and predicts the clock and data pin levels,
// the busy flag and command acceptance of every result. Checking is done in
// order of arrival. The bench opens with a table of directed requests and then
// sends random command sequences, each followed by the ticks that finish it.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module led_driver_two_wire_sender_tb
  import ldts_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;

  localparam res_t IDLE_HIGH    = '{accepted: 1'b0, busy_res: 1'b0, data_line: 1'b1,
                                    clock_line: 1'b1};
  localparam res_t TAKEN_HIGH   = '{accepted: 1'b1, busy_res: 1'b1, data_line: 1'b1,
                                    clock_line: 1'b1};
  localparam res_t REFUSED_HIGH = '{accepted: 1'b0, busy_res: 1'b1, data_line: 1'b1,
                                    clock_line: 1'b1};

  typedef struct {
    logic [2:0] cmd;
    logic [2:0] pos;
    logic [7:0] seg;
    logic [2:0] lvl;
    bit         typed;
    bit         drain;
    res_t       want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  // Predicted sender state.
  seq_t       link_state = SEQ_IDLE;
  int         frame_tick = 0;
  logic [7:0] cmd_byte = '0;
  logic [2:0] wr_addr = '0;
  logic [7:0] wr_data = '0;
  logic [2:0] clear_idx = '0;
  logic       colon_lit = 1'b0;
  logic [7:0] colon_byte = '0;
  logic [1:0] pins = 2'b11;

  res_t pending_levels[$];
  row_t plan[$];

  int  n_errors = 0;
  int  n_checked = 0;
  int  n_ticks = 0;
  int  n_taken = 0;
  int  n_refused = 0;
  int  cycles = 0;
  bit  steady_in = 1'b0;
  bit  steady_out = 1'b0;

  led_driver_two_wire_sender DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_levels.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Levels {clock, data} of step k of a byte slot: eight bits, then acknowledge.
  function automatic logic [1:0] slot_levels(input logic [7:0] b, input int k);
    if (k < 16) begin
      return {1'(k % 2), b[k / 2]};
    end
    return {1'(k - 16), 1'b0};
  endfunction

  function automatic logic [1:0] command_levels(input logic [7:0] b, input int t);
    if (t == 0) return 2'b11;
    if (t == 1) return 2'b10;
    if (t < 20) return slot_levels(b, t - 2);
    if (t == 20) return 2'b00;
    return 2'b10;
  endfunction

  function automatic logic [1:0] write_levels(input logic [2:0] addr, input logic [7:0] data,
                                              input int t);
    if (t < 22) return command_levels(FIXED_ADDR_CMD, t);
    if (t == 22) return 2'b11;
    if (t == 23) return 2'b10;
    if (t < 42) return slot_levels(ADDR_BASE | {5'd0, addr}, t - 24);
    if (t < 60) return slot_levels(data, t - 42);
    if (t == 60) return 2'b00;
    if (t == 61) return 2'b10;
    return 2'b11;
  endfunction

  function automatic void advance_frame();
    int   len;
    logic is_data;
    is_data = (link_state == SEQ_INIT_CLEAR) || (link_state == SEQ_ONE_DATA);
    len = is_data ? DATA_FRAME_TICKS : CMD_FRAME_TICKS;
    if (frame_tick >= len) frame_tick = 0;
    pins = is_data ? write_levels(wr_addr, wr_data, frame_tick)
                   : command_levels(cmd_byte, frame_tick);
    frame_tick++;
    if (frame_tick < len) return;
    frame_tick = 0;
    case (link_state)
      SEQ_INIT_MODE: begin
        link_state = SEQ_INIT_CTRL;
        cmd_byte = CTRL_FULL_CMD;
      end
      SEQ_INIT_CTRL: begin
        link_state = SEQ_INIT_CLEAR;
        clear_idx = '0;
        wr_addr = '0;
        wr_data = '0;
      end
      SEQ_INIT_CLEAR: begin
        if (int'(clear_idx) + 1 >= DIGIT_COUNT) begin
          link_state = SEQ_IDLE;
        end else begin
          clear_idx = clear_idx + 3'd1;
          wr_addr = clear_idx;
          wr_data = '0;
        end
      end
      default: begin
        link_state = SEQ_IDLE;
      end
    endcase
  endfunction

  function automatic res_t next_pin_levels(input logic [2:0] cmd, input logic [2:0] pos,
                                           input logic [7:0] seg, input logic [2:0] lvl);
    res_t r;
    logic idle;
    r = '0;
    idle = (link_state == SEQ_IDLE);
    if (cmd == CMD_TICK) begin
      if (!idle) advance_frame();
    end else if (idle && cmd <= CMD_COLON_OFF) begin
      r.accepted = 1'b1;
      frame_tick = 0;
      case (cmd)
        CMD_INIT: begin
          link_state = SEQ_INIT_MODE;
          cmd_byte = MODE_CMD;
          clear_idx = '0;
        end
        CMD_BRIGHT: begin
          link_state = SEQ_ONE_CMD;
          cmd_byte = BRIGHT_BASE | {5'd0, lvl};
        end
        CMD_WRITE: begin
          link_state = SEQ_ONE_DATA;
          wr_addr = pos;
          wr_data = seg | (colon_lit ? DOT_MASK : 8'd0);
          if (pos == COLON_POSITION) colon_byte = seg;
        end
        CMD_COLON_ON: begin
          colon_lit = 1'b1;
          link_state = SEQ_ONE_DATA;
          wr_addr = COLON_POSITION;
          wr_data = colon_byte | DOT_MASK;
        end
        default: begin
          colon_lit = 1'b0;
          link_state = SEQ_ONE_DATA;
          wr_addr = COLON_POSITION;
          wr_data = colon_byte;
        end
      endcase
    end
    r.clock_line = pins[1];
    r.data_line = pins[0];
    r.busy_res = (link_state != SEQ_IDLE);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (n_errors < 20) begin
      $display("mismatch at result %0d: %s got %0d expected %0d", n_checked, what, got,
               want);
    end
    n_errors++;
  endtask

  task automatic send_request(input logic [2:0] cmd, input logic [2:0] pos,
                              input logic [7:0] seg, input logic [2:0] lvl,
                              input bit typed, input res_t want);
    int   gap;
    logic was_busy;
    res_t r;
    if ($urandom_range(0, 49) == 0) steady_in = !steady_in;
    gap = steady_in ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {2'b00, lvl, seg, pos};
    do @(posedge clk); while (!in_tready);
    was_busy = (link_state != SEQ_IDLE);
    r = next_pin_levels(cmd, pos, seg, lvl);
    if (cmd == CMD_TICK) begin
      if (was_busy) n_ticks++;
    end else if (r.accepted) begin
      n_taken++;
    end else begin
      n_refused++;
    end
    pending_levels.push_back(typed ? want : r);
  endtask

  task automatic send_tick();
    send_request(CMD_TICK, 3'($urandom), 8'($urandom), 3'($urandom), 1'b0, '0);
  endtask

  task automatic add_row(input logic [2:0] cmd, input logic [2:0] pos,
                         input logic [7:0] seg, input logic [2:0] lvl, input bit drain,
                         input bit typed, input res_t want);
    row_t row;
    row = '{cmd: cmd, pos: pos, seg: seg, lvl: lvl, typed: typed, drain: drain, want: want};
    plan.push_back(row);
  endtask

  initial begin : result_side
    int   stall;
    res_t got;
    res_t want;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) steady_out = !steady_out;
      stall = steady_out ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = res_t'(out_tdata[3:0]);
      if (pending_levels.size() == 0) begin
        report_mismatch("result with nothing outstanding, bits", int'(out_tdata), -1);
      end else begin
        want = pending_levels.pop_front();
        if (got.clock_line !== want.clock_line)
          report_mismatch("clock_line", got.clock_line, want.clock_line);
        if (got.data_line !== want.data_line)
          report_mismatch("data_line", got.data_line, want.data_line);
        if (got.busy_res !== want.busy_res)
          report_mismatch("busy_res", got.busy_res, want.busy_res);
        if (got.accepted !== want.accepted)
          report_mismatch("accepted", got.accepted, want.accepted);
      end
      n_checked++;
    end
  end

  initial begin : request_side
    int   base;
    int   pick;
    bit   paused;
    logic [2:0] cmd;
    logic [2:0] pos;
    row_t row;

    // An idle tick and unused codes, commands refused while busy, and each command kind run to its end.
    add_row(CMD_TICK, 3'd7, 8'hFF, 3'd7, 1'b0, 1'b1, IDLE_HIGH);
    add_row(CMD_SPARE_LO, 3'd0, 8'h00, 3'd0, 1'b0, 1'b1, IDLE_HIGH);
    add_row(CMD_SPARE_HI, 3'd7, 8'hFF, 3'd7, 1'b0, 1'b1, IDLE_HIGH);
    add_row(CMD_INIT, 3'd0, 8'h00, 3'd0, 1'b0, 1'b1, TAKEN_HIGH);
    add_row(CMD_WRITE, 3'd2, 8'h3C, 3'd0, 1'b0, 1'b1, REFUSED_HIGH);
    add_row(CMD_TICK, 3'd0, 8'h00, 3'd0, 1'b1, 1'b0, '0);
    add_row(CMD_BRIGHT, 3'd0, 8'h00, 3'd0, 1'b1, 1'b0, '0);
    add_row(CMD_BRIGHT, 3'd7, 8'hFF, 3'd7, 1'b1, 1'b0, '0);
    add_row(CMD_WRITE, 3'd0, 8'h00, 3'd0, 1'b1, 1'b0, '0);
    add_row(CMD_WRITE, COLON_POSITION, 8'hFF, 3'd0, 1'b1, 1'b0, '0);
    add_row(CMD_COLON_ON, 3'd0, 8'h00, 3'd0, 1'b1, 1'b0, '0);
    add_row(CMD_WRITE, 3'd5, 8'h5A, 3'd2, 1'b1, 1'b0, '0);
    add_row(CMD_WRITE, COLON_POSITION, 8'h00, 3'd5, 1'b1, 1'b0, '0);
    add_row(CMD_COLON_OFF, 3'd0, 8'h00, 3'd0, 1'b1, 1'b0, '0);
    add_row(CMD_WRITE, 3'd7, 8'hA5, 3'd0, 1'b1, 1'b0, '0);
    add_row(CMD_WRITE, 3'd6, 8'h7F, 3'd0, 1'b1, 1'b0, '0);
    add_row(CMD_COLON_ON, 3'd0, 8'h00, 3'd0, 1'b0, 1'b0, '0);
    add_row(CMD_BRIGHT, 3'd0, 8'h00, 3'd3, 1'b0, 1'b1, REFUSED_HIGH);
    add_row(CMD_TICK, 3'd0, 8'h00, 3'd0, 1'b1, 1'b0, '0);
    add_row(CMD_COLON_OFF, 3'd0, 8'h00, 3'd0, 1'b1, 1'b0, '0);
    add_row(CMD_INIT, 3'd7, 8'hFF, 3'd7, 1'b1, 1'b0, '0);
    add_row(CMD_TICK, 3'd0, 8'h00, 3'd0, 1'b0, 1'b1, IDLE_HIGH);
    add_row(CMD_SPARE_HI, 3'd0, 8'h00, 3'd0, 1'b0, 1'b1, IDLE_HIGH);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      send_request(row.cmd, row.pos, row.seg, row.lvl, row.typed, row.want);
      if (row.drain) begin
        while (link_state != SEQ_IDLE) send_tick();
      end
    end

    // Random command sequences, each followed by the ticks that finish it.
    base = n_ticks + n_taken;
    paused = 1'b0;
    while (n_ticks + n_taken - base < RANDOM_ITEMS) begin
      if (!paused && n_ticks + n_taken - base > RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_levels.size() > 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) cmd = CMD_INIT;
      else if (pick < 20) cmd = CMD_BRIGHT;
      else if (pick < 60) cmd = CMD_WRITE;
      else if (pick < 70) cmd = CMD_COLON_ON;
      else if (pick < 80) cmd = CMD_COLON_OFF;
      else if (pick < 85) cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      else cmd = CMD_TICK;
      pos = ($urandom_range(0, 3) == 0) ? COLON_POSITION : 3'($urandom);
      send_request(cmd, pos, 8'($urandom), 3'($urandom), 1'b0, '0);
      while (link_state != SEQ_IDLE) begin
        if ($urandom_range(0, 39) == 0) begin
          send_request(3'($urandom_range(CMD_INIT, CMD_SPARE_HI)), 3'($urandom),
                       8'($urandom), 3'($urandom), 1'b0, '0);
        end else begin
          send_tick();
        end
      end
    end
    in_tvalid <= 1'b0;

    while (pending_levels.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d commands taken, %0d refused and %0d frame ticks", n_taken,
             n_refused, n_ticks);
    $display("%0d results compared in %0d cycles, %0d mismatches", n_checked, cycles,
             n_errors);
    if (n_errors == 0 && pending_levels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
